FILE: design/xffe_pkg.sv
// ----------------------------------------------------------------------------
// xffe_pkg
// Shared types and constants for the XID frame field extractor.
// ----------------------------------------------------------------------------
package xffe_pkg;

  // Group and parameter identifiers
  localparam logic [7:0] GRP_PUBLIC  = 8'h80;
  localparam logic [7:0] GRP_PRIVATE = 8'hf0;
  localparam logic [7:0] PAR_DEST    = 8'h83;
  localparam logic [7:0] PAR_POS     = 8'h84;

  // Bytes a parameter must carry before it is captured
  localparam int unsigned CAPTURE_BYTES = 4;

  // Parser phase
  typedef enum logic [2:0] {
    PH_GID,
    PH_GLENHI,
    PH_GLENLO,
    PH_GSKIP,
    PH_PID,
    PH_PLEN,
    PH_PDATA,
    PH_DONE
  } phase_t;

  // Kind of the parameter being walked
  typedef enum logic [1:0] {
    PK_OTHER,
    PK_DEST,
    PK_POS
  } param_kind_t;

  // Input request: one byte of the XID information field
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Result request: one per frame
  typedef struct packed {
    logic               private_found;
    logic               dest_valid;
    logic [31:0]        dest_airport;
    logic               pos_valid;
    logic signed [11:0] latitude_tenths;
    logic signed [11:0] longitude_tenths;
    logic [7:0]         altitude_kft;
  } out_t;

endpackage

FILE: design/xffe_parser.sv
// ----------------------------------------------------------------------------
// xffe_parser
// Group/parameter walker: holds the parse state and forms the frame result.
// ----------------------------------------------------------------------------
module xffe_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  xffe_pkg::in_t req,
  output xffe_pkg::out_t res
);
  import xffe_pkg::*;

  phase_t      phase, phase_next;
  logic        grp_priv, grp_priv_next;
  logic [15:0] grp_rem, grp_rem_next;
  param_kind_t pkind, pkind_next;
  logic [7:0]  par_rem, par_rem_next;
  logic [2:0]  par_idx, par_idx_next;
  logic [31:0] stage, stage_next;
  logic [31:0] dest_shift, dest_shift_next;
  logic [31:0] pos_bytes, pos_bytes_next;
  logic        f_priv, f_priv_next;
  logic        f_dest, f_dest_next;
  logic        f_pos, f_pos_next;

  logic [7:0]  b;
  logic        finish;
  logic        pv;

  assign b = req.data_byte;

  always_comb begin
    phase_next      = phase;
    grp_priv_next   = grp_priv;
    grp_rem_next    = grp_rem;
    pkind_next      = pkind;
    par_rem_next    = par_rem;
    par_idx_next    = par_idx;
    stage_next      = stage;
    dest_shift_next = dest_shift;
    pos_bytes_next  = pos_bytes;
    f_priv_next     = f_priv;
    f_dest_next     = f_dest;
    f_pos_next      = f_pos;
    finish          = 1'b0;

    if (step) begin
      unique case (phase)
        PH_GID: begin
          grp_priv_next = (b == GRP_PRIVATE);
          if (b == GRP_PRIVATE) begin
            f_priv_next = 1'b1;
          end
          phase_next = PH_GLENHI;
        end
        PH_GLENHI: begin
          grp_rem_next = {b, 8'h00};
          phase_next   = PH_GLENLO;
        end
        PH_GLENLO: begin
          grp_rem_next = {grp_rem[15:8], b};
          if (grp_priv) begin
            phase_next = (grp_rem_next != 16'd0) ? PH_PID : PH_DONE;
          end else begin
            phase_next = (grp_rem_next != 16'd0) ? PH_GSKIP : PH_GID;
          end
        end
        PH_GSKIP: begin
          grp_rem_next = grp_rem - 16'd1;
          if (grp_rem == 16'd1) begin
            phase_next = PH_GID;
          end
        end
        PH_PID: begin
          if (b == PAR_DEST) begin
            pkind_next = PK_DEST;
          end else if (b == PAR_POS) begin
            pkind_next = PK_POS;
          end else begin
            pkind_next = PK_OTHER;
          end
          grp_rem_next = grp_rem - 16'd1;
          phase_next   = (grp_rem != 16'd1) ? PH_PLEN : PH_DONE;
        end
        PH_PLEN: begin
          // zero-length parameter has no bytes, so nothing is captured
          par_rem_next = b;
          par_idx_next = 3'd0;
          stage_next   = 32'd0;
          grp_rem_next = grp_rem - 16'd1;
          if (grp_rem == 16'd1) begin
            phase_next = PH_DONE;
          end else if (b == 8'd0) begin
            phase_next = PH_PID;
          end else begin
            phase_next = PH_PDATA;
          end
        end
        PH_PDATA: begin
          if (par_idx < 3'(CAPTURE_BYTES)) begin
            case (par_idx[1:0])
              2'd0:    stage_next[31:24] = b;
              2'd1:    stage_next[23:16] = b;
              2'd2:    stage_next[15:8]  = b;
              default: stage_next[7:0]   = b;
            endcase
            par_idx_next = par_idx + 3'd1;
          end
          par_rem_next = par_rem - 8'd1;
          grp_rem_next = grp_rem - 16'd1;
          if (par_rem == 8'd1) begin
            finish     = 1'b1;
            phase_next = (grp_rem != 16'd1) ? PH_PID : PH_DONE;
          end else if (grp_rem == 16'd1) begin
            // group ended mid-parameter: dropped
            phase_next = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    if (finish && (par_idx_next >= 3'(CAPTURE_BYTES))) begin
      if (pkind == PK_DEST) begin
        dest_shift_next = stage_next;
        f_dest_next     = 1'b1;
      end else if (pkind == PK_POS) begin
        pos_bytes_next = stage_next;
        f_pos_next     = 1'b1;
      end
    end

    pv = f_pos_next && (pos_bytes_next[31:8] != 24'd0);

    res.private_found    = f_priv_next;
    res.dest_valid       = f_dest_next;
    res.dest_airport     = f_dest_next ? dest_shift_next : 32'd0;
    res.pos_valid        = pv;
    res.latitude_tenths  = pv ? pos_bytes_next[31:20] : 12'sd0;
    res.longitude_tenths = pv ? pos_bytes_next[19:8] : 12'sd0;
    res.altitude_kft     = pv ? pos_bytes_next[7:0] : 8'd0;
  end

  // Control state: cleared by reset and at the end of each frame
  always_ff @(posedge clk) begin
    if (rst || (step && req.last_byte)) begin
      phase    <= PH_GID;
      grp_priv <= 1'b0;
      grp_rem  <= 16'd0;
      pkind    <= PK_OTHER;
      par_rem  <= 8'd0;
      par_idx  <= 3'd0;
      f_priv   <= 1'b0;
      f_dest   <= 1'b0;
      f_pos    <= 1'b0;
    end else begin
      phase    <= phase_next;
      grp_priv <= grp_priv_next;
      grp_rem  <= grp_rem_next;
      pkind    <= pkind_next;
      par_rem  <= par_rem_next;
      par_idx  <= par_idx_next;
      f_priv   <= f_priv_next;
      f_dest   <= f_dest_next;
      f_pos    <= f_pos_next;
    end
  end

  // Data: only read under a flag or after being set in PH_PLEN
  always_ff @(posedge clk) begin
    stage      <= stage_next;
    dest_shift <= dest_shift_next;
    pos_bytes  <= pos_bytes_next;
  end

endmodule

FILE: design/xffe_out_reg.sv
// ----------------------------------------------------------------------------
// xffe_out_reg
// Result register: holds one frame result until the consumer takes it.
// ----------------------------------------------------------------------------
module xffe_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  xffe_pkg::out_t load_data,
  output logic           valid,
  input  logic           stall,
  output xffe_pkg::out_t data
);
  import xffe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

FILE: design/xid_frame_field_extractor.sv
// ----------------------------------------------------------------------------
// xid_frame_field_extractor
// Walks an XID information field byte by byte and reports destination
// airport and aircraft position from the first private parameter group.
// ----------------------------------------------------------------------------
// One byte request is taken every clock cycle unless byte_stall is raised.
// Each byte updates the parse state in the same cycle it is accepted; the
// byte marked last_byte also loads the frame result into the output
// register, so the result shows in the cycle after that byte and the parser
// is back at the start of a new frame on the very next cycle. Only one
// register level (parse state to result register) sets the rate. While a
// result is held under result_stall, the block keeps taking bytes of the
// next frame and only stalls a last byte, since that one needs the result
// register. Groups 0x80 and unknown groups are skipped by length; the first
// 0xf0 group is walked as parameters (0x83 destination, 0x84 position) and
// everything after it is ignored. A parameter shorter than four bytes, or
// cut off by its group or the frame end, is not captured; the last complete
// capture wins. Result fields that are not valid read as zero.
// ----------------------------------------------------------------------------
module xid_frame_field_extractor (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  xffe_pkg::in_t  byte_req,
  output logic           result_valid,
  input  logic           result_stall,
  output xffe_pkg::out_t result
);
  import xffe_pkg::*;

  logic accept;
  out_t frame_res;

  // Last byte needs a free (or draining) result register
  assign byte_stall = result_valid && result_stall && byte_req.last_byte;
  assign accept     = byte_valid && !byte_stall;

  xffe_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .req  (byte_req),
    .res  (frame_res)
  );

  xffe_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && byte_req.last_byte),
    .load_data (frame_res),
    .valid     (result_valid),
    .stall     (result_stall),
    .data      (result)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xid_frame_field_extractor: frames of XID bytes go
// in, one frame summary comes out per last byte and is checked field by field
// against a byte-level parse model kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import xffe_pkg::*;

  typedef logic [7:0] frame_bytes_t[$];

  logic clk = 1'b0;
  logic rst;
  logic byte_valid;
  logic byte_stall;
  in_t  byte_req;
  logic result_valid;
  logic result_stall;
  out_t result;

  xid_frame_field_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_req     (byte_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Parse model state, mirrors what the block must hold between bytes
  phase_t      ph;
  logic [7:0]  grp;
  logic [15:0] grp_left;
  logic [7:0]  par_id;
  logic [7:0]  par_left;
  int unsigned par_cnt;
  logic [31:0] par_stage;
  logic [31:0] dest_word;
  logic [31:0] pos_word;
  logic        priv_seen;
  logic        dest_got;
  logic        pos_got;

  out_t frame_results_q[$];   // one summary per frame whose last byte went in
  out_t want_res;
  int   mismatch_count;
  int   bytes_sent;
  logic idle_on;              // 0 gives stretches with no gaps and no stalls

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_parse();
    ph        = PH_GID;
    grp       = '0;
    grp_left  = '0;
    par_id    = '0;
    par_left  = '0;
    par_cnt   = 0;
    par_stage = '0;
    dest_word = '0;
    pos_word  = '0;
    priv_seen = 1'b0;
    dest_got  = 1'b0;
    pos_got   = 1'b0;
  endtask

  // Advance the parse model by one accepted byte request; on the last byte
  // queue the frame summary and start over.
  task automatic predict_byte(in_t req);
    logic [7:0]  b;
    logic [11:0] lat;
    logic [11:0] lon;
    logic        pv;
    out_t        r;
    b = req.data_byte;
    case (ph)
      PH_GID: begin
        grp = b;
        if (b == GRP_PRIVATE) priv_seen = 1'b1;
        ph = PH_GLENHI;
      end
      PH_GLENHI: begin
        grp_left = {b, 8'h00};
        ph = PH_GLENLO;
      end
      PH_GLENLO: begin
        grp_left[7:0] = b;
        // first private group is walked, an empty one ends the walk at once
        if (grp == GRP_PRIVATE) ph = (grp_left != 0) ? PH_PID : PH_DONE;
        else ph = (grp_left != 0) ? PH_GSKIP : PH_GID;
      end
      PH_GSKIP: begin
        grp_left--;
        if (grp_left == 0) ph = PH_GID;
      end
      PH_PID: begin
        par_id = b;
        grp_left--;
        ph = (grp_left != 0) ? PH_PLEN : PH_DONE;
      end
      PH_PLEN: begin
        // a zero-length parameter holds no bytes, so nothing is captured
        par_left  = b;
        par_cnt   = 0;
        par_stage = '0;
        grp_left--;
        if (b == 0) ph = (grp_left != 0) ? PH_PID : PH_DONE;
        else ph = (grp_left != 0) ? PH_PDATA : PH_DONE;
      end
      PH_PDATA: begin
        if (par_cnt < CAPTURE_BYTES) begin
          par_stage[8 * (CAPTURE_BYTES - 1 - par_cnt) +: 8] = b;
          par_cnt++;
        end
        par_left--;
        grp_left--;
        if (par_left == 0) begin
          // capture only on the final data byte of a long enough parameter
          if (par_cnt >= CAPTURE_BYTES) begin
            if (par_id == PAR_DEST) begin
              dest_word = par_stage;
              dest_got  = 1'b1;
            end else if (par_id == PAR_POS) begin
              pos_word = par_stage;
              pos_got  = 1'b1;
            end
          end
          ph = (grp_left != 0) ? PH_PID : PH_DONE;
        end else if (grp_left == 0) begin
          ph = PH_DONE;   // cut short by its group
        end
      end
      default: ph = PH_DONE;
    endcase

    if (req.last_byte) begin
      lat = pos_word[31:20];
      lon = pos_word[19:8];
      pv  = pos_got && ((lat | lon) != 0);
      r.private_found    = priv_seen;
      r.dest_valid       = dest_got;
      r.dest_airport     = dest_got ? dest_word : '0;
      r.pos_valid        = pv;
      r.latitude_tenths  = pv ? lat : '0;
      r.longitude_tenths = pv ? lon : '0;
      r.altitude_kft     = pv ? pos_word[7:0] : '0;
      frame_results_q.push_back(r);
      clear_parse();
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high across back-to-back requests.
  task automatic send_byte(in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_req   <= req;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_byte(req);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(frame_bytes_t fr);
    in_t req;
    for (int i = 0; i < fr.size(); i++) begin
      req.data_byte = fr[i];
      req.last_byte = (i == fr.size() - 1);
      send_byte(req);
    end
  endtask

  // Hold off the sender until every frame summary has come back
  task automatic drain_results();
    byte_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed frames
  // --------------------------------------------------------------------------

  // Frame ends on a lone private id: only private_found is set
  task automatic t_header_cut();
    frame_bytes_t fr;
    fr = {GRP_PRIVATE};
    send_frame(fr);
  endtask

  // Unknown empty group, then an empty private group ends the walk
  task automatic t_empty_private();
    frame_bytes_t fr;
    fr = {8'h12, 8'h00, 8'h00, GRP_PRIVATE, 8'h00, 8'h00};
    send_frame(fr);
  endtask

  // Public group skipped, destination and position captured with latitude at
  // its minimum and longitude at its maximum, trailing byte ignored
  task automatic t_full_capture();
    frame_bytes_t fr;
    fr = {GRP_PUBLIC, 8'h00, 8'h01, 8'hff,
          GRP_PRIVATE, 8'h00, 8'h0c,
          PAR_DEST, 8'h04, 8'h4b, 8'h4a, 8'h46, 8'h4b,
          PAR_POS, 8'h04, 8'h80, 8'h07, 8'hff, 8'h00,
          8'hff};
    send_frame(fr);
  endtask

  // Short destination dropped, zero position kept, then a position cut short
  // by the frame end leaves the zero position in place
  task automatic t_short_zero_cut();
    frame_bytes_t fr;
    fr = {GRP_PRIVATE, 8'h00, 8'h12,
          PAR_DEST, 8'h03, 8'h41, 8'h42, 8'h43,
          PAR_POS, 8'h04, 8'h00, 8'h00, 8'h00, 8'h2a,
          PAR_POS, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44};
    send_frame(fr);
  endtask

  // --------------------------------------------------------------------------
  // Random frames: mostly well-formed group layouts with random content,
  // some wrong lengths, truncations and plain noise
  // --------------------------------------------------------------------------
  task automatic t_random_frames();
    frame_bytes_t fr;
    int          n_frames;
    int          r;
    int          hdr;
    int          glen;
    int          plen;
    int          cut;
    logic [15:0] len;
    logic [7:0]  id;
    logic [7:0]  b;
    logic        zero_pos;
    n_frames = 0;
    while (bytes_sent < 1350) begin
      fr.delete();
      idle_on = (n_frames % 16) >= 4;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 12)) fr.push_back(8'($urandom));
      end else begin
        // groups ahead of the private one: public or unknown, skipped by length
        repeat ($urandom_range(0, 2)) begin
          id = ($urandom_range(0, 1) != 0) ? GRP_PUBLIC : 8'($urandom);
          if (id == GRP_PRIVATE) id = GRP_PUBLIC;
          len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(256, 300))
                                             : 16'($urandom_range(0, 6));
          fr.push_back(id);
          fr.push_back(len[15:8]);
          fr.push_back(len[7:0]);
          repeat (len) fr.push_back(8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) begin
          fr.push_back(GRP_PRIVATE);
          hdr = fr.size();
          fr.push_back(8'h00);
          fr.push_back(8'h00);
          glen = 0;
          repeat ($urandom_range(0, 4)) begin
            r = $urandom_range(0, 9);
            id = (r < 4) ? PAR_DEST : (r < 8) ? PAR_POS : 8'($urandom);
            plen = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 8);
            zero_pos = ($urandom_range(0, 5) == 0);
            fr.push_back(id);
            fr.push_back(8'(plen));
            for (int i = 0; i < plen; i++) begin
              b = 8'($urandom);
              if (id == PAR_POS && zero_pos && i < 3) b = 8'h00;
              fr.push_back(b);
            end
            glen += 2 + plen;
          end
          // wrong declared length: cuts a parameter or pulls in trailing bytes
          if ($urandom_range(0, 7) == 0) glen = $urandom_range(0, glen + 3);
          len = 16'(glen);
          fr[hdr]     = len[15:8];
          fr[hdr + 1] = len[7:0];
        end
        // anything after the private group, sometimes another private id
        if ($urandom_range(0, 3) == 0) fr.push_back(GRP_PRIVATE);
        repeat ($urandom_range(0, 3)) fr.push_back(8'($urandom));
        if (fr.size() == 0) fr.push_back(8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, fr.size());
        while (fr.size() > cut) void'(fr.pop_back());
      end
      send_frame(fr);
      n_frames++;
      if (n_frames % 40 == 39) drain_results();
    end
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, check against the oldest summary
  // --------------------------------------------------------------------------
  initial begin : stall_gen
    int hold;
    result_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (frame_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result with none expected, actual %h", $time, result);
      end else begin
        want_res = frame_results_q.pop_front();
        check_field("private_found", want_res.private_found, result.private_found);
        check_field("dest_valid", want_res.dest_valid, result.dest_valid);
        check_field("dest_airport", want_res.dest_airport, result.dest_airport);
        check_field("pos_valid", want_res.pos_valid, result.pos_valid);
        check_field("latitude_tenths", want_res.latitude_tenths,
                    result.latitude_tenths);
        check_field("longitude_tenths", want_res.longitude_tenths,
                    result.longitude_tenths);
        check_field("altitude_kft", want_res.altitude_kft, result.altitude_kft);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    byte_valid     = 1'b0;
    byte_req       = '0;
    idle_on        = 1'b1;
    mismatch_count = 0;
    bytes_sent     = 0;
    clear_parse();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    t_header_cut();
    t_empty_private();
    t_full_capture();
    drain_results();
    t_short_zero_cut();
    drain_results();
    t_random_frames();
    drain_results();

    // result shows in the cycle after the last byte; allow some margin
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && frame_results_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

FILE: sim.f
design/xffe_pkg.sv
design/xffe_parser.sv
design/xffe_out_reg.sv
design/xid_frame_field_extractor.sv
test/tb.sv
